/* hdl/slcs_pkg.sv */
package slcs_pkg;

    localparam int FRAME_LEN = 10;
    localparam int IDX_W     = $clog2(FRAME_LEN);

    localparam logic [0:0] REG_TIMEOUT   = 1'b0;
    localparam logic [0:0] REG_SIM_FAULT = 1'b1;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_C      = 8'h43;
    localparam logic [7:0] CH_B      = 8'h42;
    localparam logic [7:0] CH_8      = 8'h38;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_7      = 8'h37;

    localparam logic [9:0] VALUE_MAX = 10'd999;

    typedef enum logic [1:0] {
        MODE_TRIG = 2'd0,
        MODE_RX   = 2'd1,
        MODE_TICK = 2'd2,
        MODE_INIT = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        KIND_TX   = 2'd0,
        KIND_DONE = 2'd1,
        KIND_FAIL = 2'd2,
        KIND_SKIP = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        FAIL_NONE     = 3'd0,
        FAIL_INVALID  = 3'd1,
        FAIL_SIM      = 3'd2,
        FAIL_REJECTED = 3'd3,
        FAIL_UNKNOWN  = 3'd4,
        FAIL_TIMEOUT  = 3'd5,
        FAIL_BUSY     = 3'd6
    } t_fail;

    typedef enum logic [2:0] {
        STEP_IDLE = 3'd0,
        STEP_C    = 3'd1,
        STEP_B    = 3'd2,
        STEP_8    = 3'd3,
        STEP_9    = 3'd4,
        STEP_A    = 3'd5,
        STEP_7    = 3'd6
    } t_step;

    typedef struct packed {
        logic [1:0]  mode;
        logic [15:0] light_num;
        logic [3:0]  out_chan;
        logic [9:0]  pulse_width;
        logic [9:0]  fire_delay;
        logic        enabled;
        logic [7:0]  rx_byte;
    } t_in;

    typedef struct packed {
        logic        is_frame;
        t_kind       kind;
        t_fail       code;
        logic [7:0]  letter;
        logic [3:0]  chan;
        logic [3:0]  d2;
        logic [3:0]  d1;
        logic [3:0]  d0;
        logic [7:0]  csum;
        logic [31:0] total;
        logic [15:0] light;
        logic [3:0]  recent_chan;
        logic        busy;
    } t_job;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  tx_byte;
        logic        last;
        t_fail       code;
        logic [31:0] total;
        logic [15:0] light;
        logic [3:0]  recent_chan;
        logic        busy;
    } t_res;

endpackage

/* hdl/slcs_front.sv */
module slcs_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [0:0]           i_cfg_idx,
    input  logic [15:0]          i_cfg_data,
    input  logic                 i_accept,
    input  slcs_pkg::t_in        i_item,
    output logic                 o_job_push,
    output slcs_pkg::t_job       o_job
);

    logic [15:0]      r_timeout;
    logic             r_sim_fault;
    logic             r_link_ready, n_link_ready;
    slcs_pkg::t_step  r_step, n_step;
    logic [3:0]       r_chan, n_chan;
    logic [9:0]       r_strobe, n_strobe;
    logic [9:0]       r_delay, n_delay;
    logic [15:0]      r_light, n_light;
    logic [15:0]      r_wait, n_wait;
    logic [31:0]      r_count, n_count;
    logic [15:0]      r_done_light, n_done_light;
    logic [3:0]       r_done_chan, n_done_chan;

    function automatic logic [7:0] cmd_letter(input slcs_pkg::t_step s);
        case (s)
            slcs_pkg::STEP_B: cmd_letter = slcs_pkg::CH_B;
            slcs_pkg::STEP_8: cmd_letter = slcs_pkg::CH_8;
            slcs_pkg::STEP_9: cmd_letter = slcs_pkg::CH_9;
            slcs_pkg::STEP_A: cmd_letter = slcs_pkg::CH_A;
            slcs_pkg::STEP_7: cmd_letter = slcs_pkg::CH_7;
            default:          cmd_letter = slcs_pkg::CH_C;
        endcase
    endfunction

    // split a value below 1000 into decimal digits by reciprocal multiplies
    function automatic logic [11:0] to_bcd(input logic [9:0] v);
        logic [15:0] p;
        logic [3:0]  h;
        logic [6:0]  r;
        logic [13:0] q;
        logic [3:0]  t;
        logic [3:0]  o;
        p = {6'd0, v} * 16'd41;
        h = p[15:12];
        r = 7'(v - 10'(h) * 10'd100);
        q = {7'd0, r} * 14'd103;
        t = q[13:10];
        o = 4'(r - 7'(t) * 7'd10);
        to_bcd = {h, t, o};
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout   <= 16'd200;
            r_sim_fault <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                slcs_pkg::REG_TIMEOUT:   r_timeout   <= i_cfg_data;
                slcs_pkg::REG_SIM_FAULT: r_sim_fault <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_ready <= 1'b0;
            r_step       <= slcs_pkg::STEP_IDLE;
            r_chan       <= '0;
            r_strobe     <= '0;
            r_delay      <= '0;
            r_light      <= '0;
            r_wait       <= '0;
            r_count      <= '0;
            r_done_light <= '0;
            r_done_chan  <= '0;
        end else if (i_accept) begin
            r_link_ready <= n_link_ready;
            r_step       <= n_step;
            r_chan       <= n_chan;
            r_strobe     <= n_strobe;
            r_delay      <= n_delay;
            r_light      <= n_light;
            r_wait       <= n_wait;
            r_count      <= n_count;
            r_done_light <= n_done_light;
            r_done_chan  <= n_done_chan;
        end
    end

    always_comb begin
        logic           has_job;
        logic           frame;
        logic           do_advance;
        slcs_pkg::t_kind kind;
        slcs_pkg::t_fail code;
        logic [9:0]     value;
        logic [11:0]    bcd;
        logic [7:0]     chan_byte;

        n_link_ready = r_link_ready;
        n_step       = r_step;
        n_chan       = r_chan;
        n_strobe     = r_strobe;
        n_delay      = r_delay;
        n_light      = r_light;
        n_wait       = r_wait;
        n_count      = r_count;
        n_done_light = r_done_light;
        n_done_chan  = r_done_chan;
        has_job      = 1'b0;
        frame        = 1'b0;
        do_advance   = 1'b0;
        kind         = slcs_pkg::KIND_TX;
        code         = slcs_pkg::FAIL_NONE;

        case (slcs_pkg::t_mode'(i_item.mode))
            slcs_pkg::MODE_TRIG: begin
                has_job = 1'b1;
                if (r_step != slcs_pkg::STEP_IDLE) begin
                    kind = slcs_pkg::KIND_FAIL;
                    code = slcs_pkg::FAIL_BUSY;
                end else if (!r_link_ready || r_timeout == 16'd0 ||
                             i_item.out_chan == 4'd0 ||
                             i_item.out_chan > 4'd9 ||
                             i_item.pulse_width == 10'd0) begin
                    n_link_ready = 1'b0;
                    kind = slcs_pkg::KIND_FAIL;
                    code = slcs_pkg::FAIL_INVALID;
                end else if (!i_item.enabled) begin
                    kind = slcs_pkg::KIND_SKIP;
                end else if (r_sim_fault) begin
                    n_link_ready = 1'b0;
                    kind = slcs_pkg::KIND_FAIL;
                    code = slcs_pkg::FAIL_SIM;
                end else begin
                    n_chan   = i_item.out_chan;
                    n_strobe = (i_item.pulse_width > slcs_pkg::VALUE_MAX) ?
                               slcs_pkg::VALUE_MAX : i_item.pulse_width;
                    n_delay  = (i_item.fire_delay > slcs_pkg::VALUE_MAX) ?
                               slcs_pkg::VALUE_MAX : i_item.fire_delay;
                    n_light  = i_item.light_num;
                    n_step   = slcs_pkg::STEP_C;
                    n_wait   = r_timeout;
                    frame    = 1'b1;
                end
            end
            slcs_pkg::MODE_RX: begin
                if (r_step != slcs_pkg::STEP_IDLE) begin
                    has_job = 1'b1;
                    if (i_item.rx_byte == slcs_pkg::CH_DOLLAR ||
                        r_step == slcs_pkg::STEP_C || r_step == slcs_pkg::STEP_B) begin
                        do_advance = 1'b1;
                    end else begin
                        n_step       = slcs_pkg::STEP_IDLE;
                        n_link_ready = 1'b0;
                        kind = slcs_pkg::KIND_FAIL;
                        code = (i_item.rx_byte == slcs_pkg::CH_AMP) ?
                               slcs_pkg::FAIL_REJECTED : slcs_pkg::FAIL_UNKNOWN;
                    end
                end
            end
            slcs_pkg::MODE_TICK: begin
                if (r_step != slcs_pkg::STEP_IDLE) begin
                    if (r_wait <= 16'd1) begin
                        has_job = 1'b1;
                        n_wait  = '0;
                        if (r_step == slcs_pkg::STEP_C || r_step == slcs_pkg::STEP_B) begin
                            do_advance = 1'b1;
                        end else begin
                            n_step       = slcs_pkg::STEP_IDLE;
                            n_link_ready = 1'b0;
                            kind = slcs_pkg::KIND_FAIL;
                            code = slcs_pkg::FAIL_TIMEOUT;
                        end
                    end else begin
                        n_wait = r_wait - 16'd1;
                    end
                end
            end
            default: begin
                n_link_ready = 1'b1;
                n_step       = slcs_pkg::STEP_IDLE;
                n_wait       = '0;
                n_count      = '0;
                n_done_light = '0;
                n_done_chan  = '0;
            end
        endcase

        if (do_advance) begin
            if (r_step == slcs_pkg::STEP_7) begin
                n_step       = slcs_pkg::STEP_IDLE;
                n_count      = r_count + 32'd1;
                n_done_light = r_light;
                n_done_chan  = r_chan;
                kind         = slcs_pkg::KIND_DONE;
            end else begin
                n_step = slcs_pkg::t_step'(r_step + 3'd1);
                n_wait = r_timeout;
                frame  = 1'b1;
            end
        end

        case (n_step)
            slcs_pkg::STEP_B: value = 10'd1;
            slcs_pkg::STEP_9: value = n_strobe;
            slcs_pkg::STEP_A: value = n_delay;
            default:          value = 10'd0;
        endcase
        bcd       = to_bcd(value);
        chan_byte = slcs_pkg::CH_ZERO + {4'd0, n_chan};

        o_job_push          = i_accept && has_job;
        o_job.is_frame      = frame;
        o_job.kind          = kind;
        o_job.code          = code;
        o_job.letter        = cmd_letter(n_step);
        o_job.chan          = n_chan;
        o_job.d2            = bcd[11:8];
        o_job.d1            = bcd[7:4];
        o_job.d0            = bcd[3:0];
        o_job.csum          = slcs_pkg::CH_DOLLAR ^ cmd_letter(n_step) ^ chan_byte ^
                              (slcs_pkg::CH_ZERO + {4'd0, bcd[11:8]}) ^
                              (slcs_pkg::CH_ZERO + {4'd0, bcd[7:4]}) ^
                              (slcs_pkg::CH_ZERO + {4'd0, bcd[3:0]});
        o_job.total         = n_count;
        o_job.light         = n_done_light;
        o_job.recent_chan   = n_done_chan;
        o_job.busy          = (n_step != slcs_pkg::STEP_IDLE);
    end

    a_busy_needs_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step != slcs_pkg::STEP_IDLE |-> r_link_ready)
        else $error("sequence running without link ready");

    a_busy_chan_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step != slcs_pkg::STEP_IDLE |-> (r_chan != 4'd0 && r_chan <= 4'd9))
        else $error("sequence running on invalid channel");

endmodule

/* hdl/slcs_fifo.sv */
module slcs_fifo #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  slcs_pkg::t_job  i_data,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output slcs_pkg::t_job  o_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    slcs_pkg::t_job   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + PTR_W'(1);
            end
            r_cnt <= r_cnt + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

/* hdl/slcs_back.sv */
module slcs_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  slcs_pkg::t_job  i_job,
    input  logic            i_job_empty,
    output logic            o_job_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output slcs_pkg::t_res  o_res
);

    localparam logic [slcs_pkg::IDX_W-1:0] LAST_IDX =
        slcs_pkg::IDX_W'(slcs_pkg::FRAME_LEN - 1);

    slcs_pkg::t_job              r_job, n_job;
    logic                        r_active, n_active;
    logic [slcs_pkg::IDX_W-1:0]  r_idx, n_idx;
    logic                        r_out_valid, n_out_valid;
    slcs_pkg::t_res              r_out, n_out;
    logic                        adv;

    function automatic logic [7:0] hex_digit(input logic [3:0] n);
        hex_digit = (n < 4'd10) ? (8'h30 + {4'd0, n}) : (8'h37 + {4'd0, n});
    endfunction

    function automatic logic [7:0] frame_byte(input slcs_pkg::t_job j,
                                              input logic [slcs_pkg::IDX_W-1:0] idx);
        case (idx)
            4'd0:    frame_byte = slcs_pkg::CH_DOLLAR;
            4'd1:    frame_byte = j.letter;
            4'd2:    frame_byte = slcs_pkg::CH_ZERO + {4'd0, j.chan};
            4'd3:    frame_byte = slcs_pkg::CH_ZERO + {4'd0, j.d2};
            4'd4:    frame_byte = slcs_pkg::CH_ZERO + {4'd0, j.d1};
            4'd5:    frame_byte = slcs_pkg::CH_ZERO + {4'd0, j.d0};
            4'd6:    frame_byte = hex_digit(j.csum[7:4]);
            4'd7:    frame_byte = hex_digit(j.csum[3:0]);
            4'd8:    frame_byte = slcs_pkg::CH_CR;
            default: frame_byte = slcs_pkg::CH_LF;
        endcase
    endfunction

    assign adv     = !r_out_valid || i_pop;
    assign o_empty = !r_out_valid;
    assign o_res   = r_out;

    always_comb begin
        n_job       = r_job;
        n_active    = r_active;
        n_idx       = r_idx;
        n_out_valid = r_out_valid && !i_pop;
        n_out       = r_out;
        o_job_pop   = 1'b0;

        if (adv) begin
            if (r_active) begin
                n_out_valid       = 1'b1;
                n_out.kind        = slcs_pkg::KIND_TX;
                n_out.tx_byte     = frame_byte(r_job, r_idx);
                n_out.last        = (r_idx == LAST_IDX);
                n_out.code        = slcs_pkg::FAIL_NONE;
                n_out.total       = r_job.total;
                n_out.light       = r_job.light;
                n_out.recent_chan = r_job.recent_chan;
                n_out.busy        = r_job.busy;
                if (r_idx == LAST_IDX) begin
                    n_active = 1'b0;
                end else begin
                    n_idx = r_idx + slcs_pkg::IDX_W'(1);
                end
            end else if (!i_job_empty) begin
                o_job_pop         = 1'b1;
                n_out_valid       = 1'b1;
                n_out.total       = i_job.total;
                n_out.light       = i_job.light;
                n_out.recent_chan = i_job.recent_chan;
                n_out.busy        = i_job.busy;
                if (i_job.is_frame) begin
                    n_out.kind    = slcs_pkg::KIND_TX;
                    n_out.tx_byte = frame_byte(i_job, '0);
                    n_out.last    = 1'b0;
                    n_out.code    = slcs_pkg::FAIL_NONE;
                    n_job         = i_job;
                    n_active      = 1'b1;
                    n_idx         = slcs_pkg::IDX_W'(1);
                end else begin
                    n_out.kind    = i_job.kind;
                    n_out.tx_byte = 8'd0;
                    n_out.last    = 1'b1;
                    n_out.code    = i_job.code;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_active    <= n_active;
            r_idx       <= n_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_out <= n_out;
    end

    a_frame_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.last |-> r_active)
        else $error("frame byte shown without the rest of its frame pending");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (r_idx != '0 && r_idx <= LAST_IDX))
        else $error("frame byte index out of range");

    a_no_pop_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> !o_job_pop)
        else $error("job taken while a frame is still going out");

endmodule

/* hdl/strobe_light_command_sequencer.sv */
// Strobe light command sequencer. Input items (trigger, reply byte, tick,
// initialize) are taken through push/full and results leave through
// empty/pop, oldest first. The front takes one input item per cycle while
// full is low and updates the sequence state at once; each item causing
// results drops one job into a QUEUE_DEPTH-entry queue. The back turns a job
// into result items at one per cycle while pop keeps taking them, through
// its output register: a command frame is 10 items, so a frame job holds the
// back until its last item is out, and any other job gives one item. Items
// with no result stay in the front. full rises while the job queue is full.
// Configuration: register 0 is the reply timeout in ticks, register 1 the
// simulated fault flag; write them only while the block is idle.
module strobe_light_command_sequencer #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_light_num,
    input  logic [3:0]  i_out_chan,
    input  logic [9:0]  i_pulse_width,
    input  logic [9:0]  i_fire_delay,
    input  logic        i_enabled,
    input  logic [7:0]  i_rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_last_of_run,
    output logic [2:0]  o_fail_code,
    output logic [31:0] o_trigger_total,
    output logic [15:0] o_recent_light,
    output logic [3:0]  o_recent_channel,
    output logic        o_busy_res
);

    slcs_pkg::t_in  item;
    slcs_pkg::t_job push_job, head_job;
    slcs_pkg::t_res res;
    logic           job_push, job_pop, job_empty;

    assign item.mode        = i_mode;
    assign item.light_num   = i_light_num;
    assign item.out_chan    = i_out_chan;
    assign item.pulse_width = i_pulse_width;
    assign item.fire_delay  = i_fire_delay;
    assign item.enabled     = i_enabled;
    assign item.rx_byte     = i_rx_byte;

    slcs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_accept   (push && !full),
        .i_item     (item),
        .o_job_push (job_push),
        .o_job      (push_job)
    );

    slcs_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (push_job),
        .o_full  (full),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_data  (head_job)
    );

    slcs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job       (head_job),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_res       (res)
    );

    assign o_kind           = res.kind;
    assign o_tx_byte        = res.tx_byte;
    assign o_last_of_run    = res.last;
    assign o_fail_code      = res.code;
    assign o_trigger_total  = res.total;
    assign o_recent_light   = res.light;
    assign o_recent_channel = res.recent_chan;
    assign o_busy_res       = res.busy;

endmodule

/* tb/sv/strobe_sequence_checker.sv */
`timescale 1ns / 1ps

module strobe_sequence_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    input  logic        push,
    input  logic        full,
    input  logic [1:0]  i_mode,
    input  logic [15:0] i_light_num,
    input  logic [3:0]  i_out_chan,
    input  logic [9:0]  i_pulse_width,
    input  logic [9:0]  i_fire_delay,
    input  logic        i_enabled,
    input  logic [7:0]  i_rx_byte,
    input  logic        empty,
    input  logic        pop,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_tx_byte,
    input  logic        i_last_of_run,
    input  logic [2:0]  i_fail_code,
    input  logic [31:0] i_trigger_total,
    input  logic [15:0] i_recent_light,
    input  logic [3:0]  i_recent_channel,
    input  logic        i_busy_res,
    output int          o_mismatches,
    output int          o_owed
);

    localparam int REPORT_LIMIT = 10;

    logic [15:0]     timeout_cfg;
    logic            fault_cfg;
    logic            link_ready;
    slcs_pkg::t_step seq_step;
    logic [3:0]      act_chan;
    logic [9:0]      act_strobe;
    logic [9:0]      act_delay;
    logic [15:0]     act_light;
    logic [15:0]     ticks_left;
    logic [31:0]     done_count;
    logic [15:0]     done_light;
    logic [3:0]      done_chan;
    slcs_pkg::t_res  owed_results[$];
    int              mismatch_total;

    function automatic void owe(slcs_pkg::t_kind kind, logic [7:0] tx, slcs_pkg::t_fail code);
        slcs_pkg::t_res r;
        r.kind        = kind;
        r.tx_byte     = tx;
        r.last        = 1'b0;
        r.code        = code;
        r.total       = done_count;
        r.light       = done_light;
        r.recent_chan = done_chan;
        r.busy        = (seq_step != slcs_pkg::STEP_IDLE);
        owed_results.insert(owed_results.size(), r);
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] n);
        if (n < 4'd10) begin
            return slcs_pkg::CH_ZERO + 8'(n);
        end
        return slcs_pkg::CH_A + 8'(n - 4'd10);
    endfunction

    function automatic void owe_frame();
        logic [7:0] frame [10];
        logic [9:0] value;
        logic [7:0] sum;
        value = 10'd0;
        frame[0] = slcs_pkg::CH_DOLLAR;
        case (seq_step)
            slcs_pkg::STEP_C: begin
                frame[1] = slcs_pkg::CH_C;
            end
            slcs_pkg::STEP_B: begin
                frame[1] = slcs_pkg::CH_B;
                value    = 10'd1;
            end
            slcs_pkg::STEP_8: begin
                frame[1] = slcs_pkg::CH_8;
            end
            slcs_pkg::STEP_9: begin
                frame[1] = slcs_pkg::CH_9;
                value    = act_strobe;
            end
            slcs_pkg::STEP_A: begin
                frame[1] = slcs_pkg::CH_A;
                value    = act_delay;
            end
            default: begin
                frame[1] = slcs_pkg::CH_7;
            end
        endcase
        if (value > slcs_pkg::VALUE_MAX) begin
            value = slcs_pkg::VALUE_MAX;
        end
        frame[2] = slcs_pkg::CH_ZERO + 8'(act_chan % 4'd10);
        frame[3] = slcs_pkg::CH_ZERO + 8'(value / 10'd100);
        frame[4] = slcs_pkg::CH_ZERO + 8'((value / 10'd10) % 10'd10);
        frame[5] = slcs_pkg::CH_ZERO + 8'(value % 10'd10);
        sum = 8'd0;
        for (int i = 0; i < 6; i++) begin
            sum = sum ^ frame[i];
        end
        frame[6] = hex_char(sum[7:4]);
        frame[7] = hex_char(sum[3:0]);
        frame[8] = slcs_pkg::CH_CR;
        frame[9] = slcs_pkg::CH_LF;
        for (int i = 0; i < slcs_pkg::FRAME_LEN; i++) begin
            owe(slcs_pkg::KIND_TX, frame[i], slcs_pkg::FAIL_NONE);
        end
    endfunction

    function automatic void advance_step();
        if (seq_step == slcs_pkg::STEP_7) begin
            seq_step   = slcs_pkg::STEP_IDLE;
            done_count = done_count + 32'd1;
            done_light = act_light;
            done_chan  = act_chan;
            owe(slcs_pkg::KIND_DONE, 8'd0, slcs_pkg::FAIL_NONE);
        end else begin
            seq_step   = slcs_pkg::t_step'(seq_step + 3'd1);
            ticks_left = timeout_cfg;
            owe_frame();
        end
    endfunction

    function automatic void abort_sequence(slcs_pkg::t_fail code);
        seq_step   = slcs_pkg::STEP_IDLE;
        link_ready = 1'b0;
        owe(slcs_pkg::KIND_FAIL, 8'd0, code);
    endfunction

    function automatic void sequencer_step(slcs_pkg::t_in it);
        int             before_n;
        slcs_pkg::t_res tail;
        before_n = owed_results.size();
        case (it.mode)
            slcs_pkg::MODE_TRIG: begin
                if (seq_step != slcs_pkg::STEP_IDLE) begin
                    owe(slcs_pkg::KIND_FAIL, 8'd0, slcs_pkg::FAIL_BUSY);
                end else if (!link_ready || timeout_cfg == 16'd0 ||
                             it.out_chan == 4'd0 || it.out_chan > 4'd9 ||
                             it.pulse_width == 10'd0) begin
                    abort_sequence(slcs_pkg::FAIL_INVALID);
                end else if (!it.enabled) begin
                    owe(slcs_pkg::KIND_SKIP, 8'd0, slcs_pkg::FAIL_NONE);
                end else if (fault_cfg) begin
                    abort_sequence(slcs_pkg::FAIL_SIM);
                end else begin
                    act_chan   = it.out_chan;
                    act_strobe = (it.pulse_width > slcs_pkg::VALUE_MAX) ?
                                 slcs_pkg::VALUE_MAX : it.pulse_width;
                    act_delay  = (it.fire_delay > slcs_pkg::VALUE_MAX) ?
                                 slcs_pkg::VALUE_MAX : it.fire_delay;
                    act_light  = it.light_num;
                    seq_step   = slcs_pkg::STEP_C;
                    ticks_left = timeout_cfg;
                    owe_frame();
                end
            end
            slcs_pkg::MODE_RX: begin
                if (seq_step != slcs_pkg::STEP_IDLE) begin
                    if (it.rx_byte == slcs_pkg::CH_DOLLAR || seq_step <= slcs_pkg::STEP_B) begin
                        advance_step();
                    end else begin
                        abort_sequence(it.rx_byte == slcs_pkg::CH_AMP ?
                                       slcs_pkg::FAIL_REJECTED : slcs_pkg::FAIL_UNKNOWN);
                    end
                end
            end
            slcs_pkg::MODE_TICK: begin
                if (seq_step != slcs_pkg::STEP_IDLE) begin
                    if (ticks_left <= 16'd1) begin
                        ticks_left = 16'd0;
                        if (seq_step <= slcs_pkg::STEP_B) begin
                            advance_step();
                        end else begin
                            abort_sequence(slcs_pkg::FAIL_TIMEOUT);
                        end
                    end else begin
                        ticks_left = ticks_left - 16'd1;
                    end
                end
            end
            default: begin
                link_ready = 1'b1;
                seq_step   = slcs_pkg::STEP_IDLE;
                ticks_left = 16'd0;
                done_count = 32'd0;
                done_light = 16'd0;
                done_chan  = 4'd0;
            end
        endcase
        if (owed_results.size() > before_n) begin
            tail      = owed_results.pop_back();
            tail.last = 1'b1;
            owed_results.insert(owed_results.size(), tail);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        slcs_pkg::t_in  arrived;
        slcs_pkg::t_res want;
        if (!i_rst_n) begin
            timeout_cfg    = 16'd200;
            fault_cfg      = 1'b0;
            link_ready     = 1'b0;
            seq_step       = slcs_pkg::STEP_IDLE;
            act_chan       = 4'd0;
            act_strobe     = 10'd0;
            act_delay      = 10'd0;
            act_light      = 16'd0;
            ticks_left     = 16'd0;
            done_count     = 32'd0;
            done_light     = 16'd0;
            done_chan      = 4'd0;
            mismatch_total = 0;
            owed_results.delete();
        end else begin
            if (pop && !empty) begin
                if (owed_results.size() == 0) begin
                    mismatch_total++;
                    if (mismatch_total <= REPORT_LIMIT) begin
                        $display("unexpected result item: kind %0d tx %02h code %0d",
                                 i_kind, i_tx_byte, i_fail_code);
                    end
                end else begin
                    want = owed_results.pop_front();
                    if (i_kind != want.kind || i_tx_byte != want.tx_byte ||
                        i_last_of_run != want.last || i_fail_code != want.code ||
                        i_trigger_total != want.total || i_recent_light != want.light ||
                        i_recent_channel != want.recent_chan || i_busy_res != want.busy) begin
                        mismatch_total++;
                        if (mismatch_total <= REPORT_LIMIT) begin
                            $display({"result mismatch: expected kind %0d tx %02h last %0d ",
                                      "code %0d total %0d light %0d chan %0d busy %0d"},
                                     want.kind, want.tx_byte, want.last, want.code,
                                     want.total, want.light, want.recent_chan, want.busy);
                            $display({"                 got      kind %0d tx %02h last %0d ",
                                      "code %0d total %0d light %0d chan %0d busy %0d"},
                                     i_kind, i_tx_byte, i_last_of_run, i_fail_code,
                                     i_trigger_total, i_recent_light, i_recent_channel,
                                     i_busy_res);
                        end
                    end
                end
            end
            if (i_cfg_we) begin
                if (i_cfg_idx == slcs_pkg::REG_TIMEOUT) begin
                    timeout_cfg = i_cfg_data;
                end else if (i_cfg_idx == slcs_pkg::REG_SIM_FAULT) begin
                    fault_cfg = i_cfg_data[0];
                end
            end
            if (push && !full) begin
                arrived.mode        = i_mode;
                arrived.light_num   = i_light_num;
                arrived.out_chan    = i_out_chan;
                arrived.pulse_width = i_pulse_width;
                arrived.fire_delay  = i_fire_delay;
                arrived.enabled     = i_enabled;
                arrived.rx_byte     = i_rx_byte;
                sequencer_step(arrived);
            end
        end
        o_mismatches <= mismatch_total;
        o_owed       <= owed_results.size();
    end

endmodule

/* tb/sv/strobe_light_command_sequencer_tb.sv */
`timescale 1ns / 1ps

module strobe_light_command_sequencer_tb;

    localparam int IDLE_LIMIT      = 3000;
    localparam int HOLD_OFF_AT     = 30;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 16;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [0:0]  i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic        push;
    logic        full;
    logic [1:0]  i_mode;
    logic [15:0] i_light_num;
    logic [3:0]  i_out_chan;
    logic [9:0]  i_pulse_width;
    logic [9:0]  i_fire_delay;
    logic        i_enabled;
    logic [7:0]  i_rx_byte;
    logic        empty;
    logic        pop;
    logic [1:0]  o_kind;
    logic [7:0]  o_tx_byte;
    logic        o_last_of_run;
    logic [2:0]  o_fail_code;
    logic [31:0] o_trigger_total;
    logic [15:0] o_recent_light;
    logic [3:0]  o_recent_channel;
    logic        o_busy_res;

    int          mismatches;
    int          owed_count;
    int          burst_left;
    int          sent_count;
    int          idle_cycles;
    bit          link_up;
    logic [15:0] timeout_now;
    logic        fault_now;

    strobe_light_command_sequencer dut (.*);

    strobe_sequence_checker checker_i (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .push             (push),
        .full             (full),
        .i_mode           (i_mode),
        .i_light_num      (i_light_num),
        .i_out_chan       (i_out_chan),
        .i_pulse_width    (i_pulse_width),
        .i_fire_delay     (i_fire_delay),
        .i_enabled        (i_enabled),
        .i_rx_byte        (i_rx_byte),
        .empty            (empty),
        .pop              (pop),
        .i_kind           (o_kind),
        .i_tx_byte        (o_tx_byte),
        .i_last_of_run    (o_last_of_run),
        .i_fail_code      (o_fail_code),
        .i_trigger_total  (o_trigger_total),
        .i_recent_light   (o_recent_light),
        .i_recent_channel (o_recent_channel),
        .i_busy_res       (o_busy_res),
        .o_mismatches     (mismatches),
        .o_owed           (owed_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial begin : receiver
        int cyc;
        int style;
        bit held;
        pop   = 1'b0;
        cyc   = 0;
        style = 0;
        held  = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && sent_count >= HOLD_OFF_AT) begin
                held = 1'b1;
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge i_clk);
            end
            cyc++;
            if (cyc % 50 == 0) begin
                style = $urandom_range(0, 3);
            end
            case (style)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                2: pop <= ($urandom_range(0, 3) == 0);
                default: pop <= ((cyc / 5) % 2 == 0);
            endcase
        end
    end

    function automatic slcs_pkg::t_in random_item();
        slcs_pkg::t_in it;
        it.mode        = 2'($urandom_range(0, 3));
        it.light_num   = 16'($urandom);
        it.out_chan    = 4'($urandom);
        it.pulse_width = 10'($urandom);
        it.fire_delay  = 10'($urandom);
        it.enabled     = 1'($urandom);
        it.rx_byte     = 8'($urandom);
        return it;
    endfunction

    task automatic send_item(input slcs_pkg::t_in it);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 8);
            @(negedge i_clk);
            push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        @(negedge i_clk);
        push          <= 1'b1;
        i_mode        <= it.mode;
        i_light_num   <= it.light_num;
        i_out_chan    <= it.out_chan;
        i_pulse_width <= it.pulse_width;
        i_fire_delay  <= it.fire_delay;
        i_enabled     <= it.enabled;
        i_rx_byte     <= it.rx_byte;
        do @(posedge i_clk); while (full);
        burst_left--;
        sent_count++;
    endtask

    task automatic send_trigger(input logic [15:0] light, input logic [3:0] chan,
                                input logic [9:0] strobe, input logic [9:0] delay,
                                input logic en);
        slcs_pkg::t_in it;
        it             = random_item();
        it.mode        = slcs_pkg::MODE_TRIG;
        it.light_num   = light;
        it.out_chan    = chan;
        it.pulse_width = strobe;
        it.fire_delay  = delay;
        it.enabled     = en;
        send_item(it);
    endtask

    task automatic send_reply(input logic [7:0] rx);
        slcs_pkg::t_in it;
        it         = random_item();
        it.mode    = slcs_pkg::MODE_RX;
        it.rx_byte = rx;
        send_item(it);
    endtask

    task automatic send_plain(input slcs_pkg::t_mode m);
        slcs_pkg::t_in it;
        it      = random_item();
        it.mode = m;
        send_item(it);
    endtask

    task automatic settle();
        @(negedge i_clk);
        push <= 1'b0;
        burst_left = 0;
        while (owed_count != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [0:0] idx, input logic [15:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    task automatic apply_settings(input logic [15:0] ticks, input logic fault);
        settle();
        write_reg(slcs_pkg::REG_TIMEOUT, ticks);
        write_reg(slcs_pkg::REG_SIM_FAULT, {15'd0, fault});
        timeout_now = ticks;
        fault_now   = fault;
    endtask

    task automatic run_sequence();
        int         pick;
        logic       en;
        logic [7:0] rx;
        if (!link_up || $urandom_range(0, 9) == 0) begin
            send_plain(slcs_pkg::MODE_INIT);
            link_up = 1'b1;
        end
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
            case ($urandom_range(0, 2))
                0: send_trigger(16'($urandom), 4'd0, 10'($urandom_range(1, 1023)),
                                10'($urandom), 1'($urandom));
                1: send_trigger(16'($urandom), 4'($urandom_range(10, 15)),
                                10'($urandom_range(1, 1023)), 10'($urandom), 1'($urandom));
                default: send_trigger(16'($urandom), 4'($urandom_range(1, 9)), 10'd0,
                                      10'($urandom), 1'($urandom));
            endcase
            link_up = 1'b0;
            return;
        end
        en = (pick >= 14);
        send_trigger(16'($urandom), 4'($urandom_range(1, 9)), 10'($urandom_range(1, 1023)),
                     10'($urandom), en);
        if (timeout_now == 16'd0) begin
            link_up = 1'b0;
            return;
        end
        if (!en) begin
            return;
        end
        if (fault_now) begin
            link_up = 1'b0;
            return;
        end
        for (int step = 1; step <= 6; step++) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                send_trigger(16'($urandom), 4'($urandom_range(1, 9)),
                             10'($urandom_range(1, 1023)), 10'($urandom), 1'b1);
            end else if (pick < 7) begin
                send_plain(slcs_pkg::MODE_INIT);
                return;
            end
            pick = $urandom_range(0, 99);
            if (pick < 10 && timeout_now <= 16'd8) begin
                repeat (timeout_now) send_plain(slcs_pkg::MODE_TICK);
                if (step >= 3) begin
                    link_up = 1'b0;
                    return;
                end
                continue;
            end
            if (pick < 30 && timeout_now > 16'd1) begin
                repeat ($urandom_range(1, timeout_now > 16'd4 ? 3 : timeout_now - 1))
                    send_plain(slcs_pkg::MODE_TICK);
            end
            pick = $urandom_range(0, 99);
            if (pick < 86) begin
                rx = slcs_pkg::CH_DOLLAR;
            end else if (pick < 92) begin
                rx = slcs_pkg::CH_AMP;
            end else begin
                rx = 8'($urandom);
            end
            send_reply(rx);
            if (rx != slcs_pkg::CH_DOLLAR && step >= 3) begin
                link_up = 1'b0;
                return;
            end
        end
    endtask

    task automatic random_phase(input int n);
        int stop_at;
        stop_at = sent_count + n;
        while (sent_count < stop_at) begin
            if ($urandom_range(0, 99) < 82) begin
                run_sequence();
            end else begin
                repeat ($urandom_range(1, 3)) send_item(random_item());
                link_up = 1'b0;
            end
        end
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_idx     = 1'b0;
        i_cfg_data    = 16'd0;
        push          = 1'b0;
        i_mode        = 2'd0;
        i_light_num   = 16'd0;
        i_out_chan    = 4'd0;
        i_pulse_width = 10'd0;
        i_fire_delay  = 10'd0;
        i_enabled     = 1'b0;
        i_rx_byte     = 8'd0;
        burst_left    = 0;
        sent_count    = 0;
        link_up       = 1'b0;
        timeout_now   = 16'd200;
        fault_now     = 1'b0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_trigger(16'h1234, 4'd5, 10'd100, 10'd50, 1'b1);
        send_reply(slcs_pkg::CH_DOLLAR);
        send_plain(slcs_pkg::MODE_TICK);
        send_plain(slcs_pkg::MODE_INIT);
        send_trigger(16'h0001, 4'd0, 10'd10, 10'd10, 1'b1);
        send_plain(slcs_pkg::MODE_INIT);
        send_trigger(16'h0002, 4'd15, 10'd10, 10'd10, 1'b1);
        send_plain(slcs_pkg::MODE_INIT);
        send_trigger(16'h0003, 4'd3, 10'd0, 10'd10, 1'b1);
        send_plain(slcs_pkg::MODE_INIT);
        send_trigger(16'h0004, 4'd3, 10'd10, 10'd10, 1'b0);
        send_trigger(16'hFFFF, 4'd9, 10'h3FF, 10'h3FF, 1'b1);
        send_trigger(16'h0000, 4'd1, 10'd1, 10'd0, 1'b1);
        send_reply(slcs_pkg::CH_AMP);
        send_reply(8'hFF);
        send_plain(slcs_pkg::MODE_TICK);
        repeat (4) send_reply(slcs_pkg::CH_DOLLAR);
        send_trigger(16'h8000, 4'd1, 10'd999, 10'd0, 1'b1);
        send_reply(slcs_pkg::CH_DOLLAR);
        send_reply(slcs_pkg::CH_DOLLAR);
        send_reply(slcs_pkg::CH_AMP);

        apply_settings(16'd3, 1'b0);
        random_phase(75);
        apply_settings(16'd1, 1'b0);
        random_phase(75);
        apply_settings(16'd0, 1'b0);
        random_phase(40);
        apply_settings(16'hFFFF, 1'b0);
        random_phase(75);
        apply_settings(16'd4, 1'b1);
        random_phase(40);
        apply_settings(16'd2, 1'b0);
        random_phase(75);
        settle();

        if (mismatches == 0 && owed_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
